// ===== src/assert_macros.svh =====
// Assertion macros shared by the peak tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge once reset is released.
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/cpt_pkg.sv =====
// Shared constants, types and helpers of the component peak tracker.
`default_nettype none

package cpt_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int COORD_BITS = 10;

  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int FIELD_W = 10;
  localparam int DEPTH_W = 10;
  localparam int MAXP_W  = 4;
  localparam int SEP_W   = 11;
  localparam int MIND_W  = 10;
  localparam int TOTAL_W = 31;
  localparam int DIST_W  = (COORD_BITS > SEP_W) ? COORD_BITS : SEP_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [TOTAL_W-1:0] COUNT_SAT = TOTAL_W'(32'h4000_0000);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DEPTH_W-1:0]    depth_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PEAKS  = 2'd0,
    CFG_SEPARATION = 2'd1,
    CFG_MIN_DEPTH  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_RANK,
    ST_EMIT
  } state_e;

  // Candidate voxel broadcast to all cells.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    depth_t depth;
  } cand_t;

  // Table update command: apply enables the merge path, take writes slot tgt.
  typedef struct packed {
    logic apply;
    logic take;
    idx_t tgt;
  } upd_t;

  typedef struct packed {
    logic load;
    logic rot;
  } rank_cmd_t;

  // Running shallowest-slot search along the chain.
  typedef struct packed {
    logic   found;
    depth_t depth;
    idx_t   idx;
  } min_t;

  // Entry circulating around the ring during ranking.
  typedef struct packed {
    logic   valid;
    depth_t depth;
    idx_t   idx;
  } ring_t;

  // Cell contents as seen by the report mux.
  typedef struct packed {
    logic   valid;
    idx_t   rank;
    depth_t depth;
    coord_t x;
    coord_t y;
    coord_t z;
  } slot_t;

  function automatic coord_t to_coord(logic [FIELD_W-1:0] v);
    return coord_t'(v);
  endfunction

  function automatic coord_t absdiff(coord_t a, coord_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== src/cpt_intf.sv =====
// Handshake channel interfaces: voxel input, peak output, register writes.
`default_nettype none

interface cpt_voxel_if;
  import cpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] voxel_x;
  logic [FIELD_W-1:0] voxel_y;
  logic [FIELD_W-1:0] voxel_z;
  logic [DEPTH_W-1:0] depth;
  logic               component_end;

  modport source (output valid, voxel_x, voxel_y, voxel_z, depth, component_end,
                  input ready);
  modport sink   (input valid, voxel_x, voxel_y, voxel_z, depth, component_end,
                  output ready);
endinterface

interface cpt_peak_if;
  import cpt_pkg::*;
  logic               valid;
  logic               ready;
  logic               peak_valid;
  logic [FIELD_W-1:0] peak_x;
  logic [FIELD_W-1:0] peak_y;
  logic [FIELD_W-1:0] peak_z;
  logic [DEPTH_W-1:0] peak_depth;
  logic [TOTAL_W-1:0] voxel_total;
  logic               last_result;

  modport source (output valid, peak_valid, peak_x, peak_y, peak_z, peak_depth,
                         voxel_total, last_result,
                  input ready);
  modport sink   (input valid, peak_valid, peak_x, peak_y, peak_z, peak_depth,
                        voxel_total, last_result,
                  output ready);
endinterface

interface cpt_cfg_if;
  import cpt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/cpt_cell.sv =====
// One peak slot: proximity test, shallowest search link and ranking ring stage.
`default_nettype none

module cpt_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cpt_pkg::idx_t      idx_i,
  input  wire cpt_pkg::cnt_t      slot_cnt_i,
  input  wire cpt_pkg::cand_t     cand_i,
  input  wire logic [cpt_pkg::SEP_W-1:0] sep_i,
  input  wire cpt_pkg::upd_t      upd_i,
  input  wire cpt_pkg::rank_cmd_t rank_cmd_i,
  input  wire logic              near_seen_i,
  output logic                   near_seen_o,
  input  wire cpt_pkg::min_t      min_i,
  output cpt_pkg::min_t          min_o,
  input  wire cpt_pkg::ring_t     ring_i,
  output cpt_pkg::ring_t         ring_o,
  output cpt_pkg::slot_t         slot_o
);
  import cpt_pkg::*;

  depth_t depth_q;
  coord_t x_q, y_q, z_q;
  ring_t  ring_q;
  idx_t   rank_q;

  logic   valid;
  coord_t dx, dy, dz, cheb;
  logic   near, first, wr, beats;

  always_comb begin
    valid = CNT_W'(idx_i) < slot_cnt_i;
    dx    = absdiff(cand_i.x, x_q);
    dy    = absdiff(cand_i.y, y_q);
    dz    = absdiff(cand_i.z, z_q);
    cheb  = dx;
    if (dy > cheb) begin
      cheb = dy;
    end
    if (dz > cheb) begin
      cheb = dz;
    end
    near        = valid && (DIST_W'(cheb) < DIST_W'(sep_i));
    first       = near && !near_seen_i;
    near_seen_o = near_seen_i | near;

    // strict compare keeps the lower slot on equal depth
    if (valid && (!min_i.found || depth_q < min_i.depth)) begin
      min_o.found = 1'b1;
      min_o.depth = depth_q;
      min_o.idx   = idx_i;
    end else begin
      min_o = min_i;
    end

    wr = (upd_i.apply && first && cand_i.depth > depth_q) ||
         (upd_i.take && upd_i.tgt == idx_i);

    beats = ring_i.valid &&
            (ring_i.depth > depth_q || (ring_i.depth == depth_q && ring_i.idx < idx_i));

    ring_o       = ring_q;
    slot_o.valid = valid;
    slot_o.rank  = rank_q;
    slot_o.depth = depth_q;
    slot_o.x     = x_q;
    slot_o.y     = y_q;
    slot_o.z     = z_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      depth_q <= cand_i.depth;
      x_q     <= cand_i.x;
      y_q     <= cand_i.y;
      z_q     <= cand_i.z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      rank_q <= '0;
    end else if (rank_cmd_i.load) begin
      ring_q.valid <= valid;
      ring_q.depth <= depth_q;
      ring_q.idx   <= idx_i;
      rank_q       <= '0;
    end else if (rank_cmd_i.rot) begin
      ring_q <= ring_i;
      if (beats) begin
        rank_q <= rank_q + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/cpt_row.sv =====
// Row of peak cells with the proximity, shallowest-search and ranking chains.
`default_nettype none

module cpt_row (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cpt_pkg::cnt_t      slot_cnt_i,
  input  wire cpt_pkg::cand_t     cand_i,
  input  wire logic [cpt_pkg::SEP_W-1:0] sep_i,
  input  wire cpt_pkg::upd_t      upd_i,
  input  wire cpt_pkg::rank_cmd_t rank_cmd_i,
  input  wire cpt_pkg::idx_t      emit_rank_i,
  output logic                   near_any_o,
  output cpt_pkg::min_t          min_o,
  output cpt_pkg::slot_t         sel_o
);
  import cpt_pkg::*;

  logic  near_chain [MAX_SLOTS+1];
  min_t  min_chain  [MAX_SLOTS+1];
  ring_t ring       [MAX_SLOTS];
  slot_t slots      [MAX_SLOTS];

  assign near_chain[0] = 1'b0;
  assign min_chain[0]  = '0;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    localparam int PREV = (i == 0) ? MAX_SLOTS - 1 : i - 1;
    cpt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(i)),
      .slot_cnt_i  (slot_cnt_i),
      .cand_i      (cand_i),
      .sep_i       (sep_i),
      .upd_i       (upd_i),
      .rank_cmd_i  (rank_cmd_i),
      .near_seen_i (near_chain[i]),
      .near_seen_o (near_chain[i+1]),
      .min_i       (min_chain[i]),
      .min_o       (min_chain[i+1]),
      .ring_i      (ring[PREV]),
      .ring_o      (ring[i]),
      .slot_o      (slots[i])
    );
  end

  assign near_any_o = near_chain[MAX_SLOTS];
  assign min_o      = min_chain[MAX_SLOTS];

  // ranks of valid cells are distinct, so at most one cell hits
  always_comb begin
    sel_o = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (slots[i].valid && slots[i].rank == emit_rank_i) begin
        sel_o = slots[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/component_peak_tracker_core.sv =====
// Top level of the component peak tracker: control, counters, config and output register.
//   voxel_i : voxels of one connected component in visit order. An item is taken
//             when valid and ready are high at a clock edge. component_end marks
//             the component's last voxel.
//   peak_o  : report items, deepest peak first (equal depth: lower slot first),
//             each with the saturating voxel count; last_result flags the final
//             one. A component without peaks reports one item with peak_valid 0.
//   cfg_i   : register writes (0 max_peaks, 1 separation, 2 min_depth), always
//             ready; write only while the block is idle.
// Timing
//   A voxel is taken in the idle state; then, in the update state, every cell
//   tests proximity in parallel and the shallowest-slot search ripples down the
//   row. Unless component_end is set, ready returns in the cycle after that.
//   On a component_end voxel the ring loads the slots in the load state and ranks
//   them by rotation in the rank state; the emit state then loads the report items
//   into the output register, one item per cycle while the receiver is ready.
// Reset and stalls
//   Reset empties the table, zeroes the counter and restores register defaults
//   (8, 4, 1). A stalled receiver holds the report; voxel input waits until the
//   last report item is in the output register, and may be taken while it waits.
`default_nettype none
`include "assert_macros.svh"

module component_peak_tracker_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpt_voxel_if.sink  voxel_i,
  cpt_peak_if.source peak_o,
  cpt_cfg_if.sink    cfg_i
);
  import cpt_pkg::*;

  // configuration registers
  logic [MAXP_W-1:0] max_peaks_q;
  logic [SEP_W-1:0]  separation_q;
  logic [MIND_W-1:0] min_depth_q;

  // control
  state_e             state_q, state_d;
  cnt_t               slot_cnt_q;
  logic [TOTAL_W-1:0] vox_cnt_q;
  idx_t               step_q;
  idx_t               emit_q;

  // accepted voxel
  cand_t cand_q;
  logic  end_q;

  // output register
  logic               out_valid_q;
  logic               out_pv_q;
  coord_t             out_x_q, out_y_q, out_z_q;
  depth_t             out_depth_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_last_q;

  logic      in_acc;
  cnt_t      lim;
  upd_t      upd;
  logic      append, replace;
  rank_cmd_t rank_cmd;
  logic      near_any;
  min_t      min_res;
  slot_t     sel;
  logic      out_load, out_last;

  assign in_acc        = voxel_i.valid && voxel_i.ready;
  assign voxel_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;

  // ---------------------------------------------------------------------------
  // Register writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_peaks_q  <= MAXP_W'(8);
      separation_q <= SEP_W'(4);
      min_depth_q  <= MIND_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_MAX_PEAKS:  max_peaks_q  <= cfg_i.data[MAXP_W-1:0];
        CFG_SEPARATION: separation_q <= cfg_i.data[SEP_W-1:0];
        CFG_MIN_DEPTH:  min_depth_q  <= cfg_i.data[MIND_W-1:0];
        default:        ;
      endcase
    end
  end

  // slot limit: zero acts as one, anything above the table size as the table size
  always_comb begin
    if (32'(max_peaks_q) > MAX_SLOTS) begin
      lim = CNT_W'(MAX_SLOTS);
    end else if (max_peaks_q == '0) begin
      lim = CNT_W'(1);
    end else begin
      lim = CNT_W'(max_peaks_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Table update decision from the chain results
  // ---------------------------------------------------------------------------
  always_comb begin
    upd.apply = (state_q == ST_UPDATE) && (cand_q.depth >= min_depth_q);
    append    = upd.apply && !near_any && (slot_cnt_q < lim);
    replace   = upd.apply && !near_any && !append && min_res.found &&
                (cand_q.depth > min_res.depth);
    upd.take  = append || replace;
    upd.tgt   = append ? slot_cnt_q[IDX_W-1:0] : min_res.idx;
  end

  assign rank_cmd.load = (state_q == ST_LOAD);
  assign rank_cmd.rot  = (state_q == ST_RANK);

  cpt_row u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_cnt_i  (slot_cnt_q),
    .cand_i      (cand_q),
    .sep_i       (separation_q),
    .upd_i       (upd),
    .rank_cmd_i  (rank_cmd),
    .emit_rank_i (emit_q),
    .near_any_o  (near_any),
    .min_o       (min_res),
    .sel_o       (sel)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || peak_o.ready);
  assign out_last = (slot_cnt_q == '0) || ((CNT_W'(emit_q) + CNT_W'(1)) == slot_cnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = end_q ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        state_d = (MAX_SLOTS > 1) ? ST_RANK : ST_EMIT;
      end
      ST_RANK: begin
        if (step_q == IDX_W'(MAX_SLOTS - 2)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && out_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cnt_q <= '0;
      vox_cnt_q  <= '0;
      step_q     <= '0;
      emit_q     <= '0;
      end_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        end_q <= voxel_i.component_end;
        if (vox_cnt_q < COUNT_SAT) begin
          vox_cnt_q <= vox_cnt_q + TOTAL_W'(1);
        end
      end
      if (append) begin
        slot_cnt_q <= slot_cnt_q + CNT_W'(1);
      end
      if (state_q == ST_LOAD) begin
        step_q <= '0;
      end else if (state_q == ST_RANK) begin
        step_q <= step_q + IDX_W'(1);
      end
      if (out_load) begin
        if (out_last) begin
          // report done: start the next component from scratch
          slot_cnt_q <= '0;
          vox_cnt_q  <= '0;
          emit_q     <= '0;
        end else begin
          emit_q <= emit_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cand_q.x     <= to_coord(voxel_i.voxel_x);
      cand_q.y     <= to_coord(voxel_i.voxel_y);
      cand_q.z     <= to_coord(voxel_i.voxel_z);
      cand_q.depth <= voxel_i.depth;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (peak_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pv_q    <= sel.valid;
      out_x_q     <= sel.x;
      out_y_q     <= sel.y;
      out_z_q     <= sel.z;
      out_depth_q <= sel.depth;
      out_total_q <= vox_cnt_q;
      out_last_q  <= out_last;
    end
  end

  assign peak_o.valid       = out_valid_q;
  assign peak_o.peak_valid  = out_pv_q;
  assign peak_o.peak_x      = FIELD_W'(out_x_q);
  assign peak_o.peak_y      = FIELD_W'(out_y_q);
  assign peak_o.peak_z      = FIELD_W'(out_z_q);
  assign peak_o.peak_depth  = out_depth_q;
  assign peak_o.voxel_total = out_total_q;
  assign peak_o.last_result = out_last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_AT(a_acc_to_update, clk_i, rst_ni, in_acc |=> state_q == ST_UPDATE,
             "accepted voxel not processed next cycle")
  `ASSERT_AT(a_cnt_grows_in_update, clk_i, rst_ni,
             (slot_cnt_q > $past(slot_cnt_q)) |-> ($past(state_q) == ST_UPDATE &&
             slot_cnt_q == $past(slot_cnt_q) + CNT_W'(1)),
             "slot count grew outside an update")
  `ASSERT_AT(a_last_clears, clk_i, rst_ni,
             (out_load && out_last) |=> (state_q == ST_IDLE && slot_cnt_q == '0 &&
             vox_cnt_q == '0),
             "report end did not clear the table")
  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, slot_cnt_q > lim && state_q == ST_UPDATE && append,
                "append beyond slot limit")

endmodule

`default_nettype wire

// ===== sim/peak_scoreboard_pkg.sv =====
// Peak table predictor and report checker for the component peak tracker bench.
`timescale 1ns / 1ps

package peak_scoreboard_pkg;
  import cpt_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } voxel_item_t;

  typedef struct packed {
    logic               peak_valid;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
    logic [DEPTH_W-1:0] depth;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } peak_item_t;

  class peak_scoreboard;
    bit [MAXP_W-1:0]     max_peaks;
    bit [SEP_W-1:0]      separation;
    bit [MIND_W-1:0]     min_depth;
    int unsigned         kept;
    bit [DEPTH_W-1:0]    kept_depth [MAX_SLOTS];
    bit [COORD_BITS-1:0] kept_x [MAX_SLOTS];
    bit [COORD_BITS-1:0] kept_y [MAX_SLOTS];
    bit [COORD_BITS-1:0] kept_z [MAX_SLOTS];
    bit [TOTAL_W-1:0]    voxels;
    peak_item_t          report_q [$];
    int unsigned         errors;

    function new();
      max_peaks  = 8;
      separation = 4;
      min_depth  = 1;
      kept       = 0;
      voxels     = 0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_PEAKS:  max_peaks  = data[MAXP_W-1:0];
        CFG_SEPARATION: separation = data[SEP_W-1:0];
        CFG_MIN_DEPTH:  min_depth  = data[MIND_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned slot_limit();
      int unsigned lim;
      lim = 32'(max_peaks);
      if (lim == 0) lim = 1;
      if (lim > MAX_SLOTS) lim = MAX_SLOTS;
      return lim;
    endfunction

    function int unsigned absd(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int unsigned chebyshev(voxel_item_t v, int unsigned s);
      int unsigned c, t;
      c = absd(int'(v.x[COORD_BITS-1:0]), int'(kept_x[s]));
      t = absd(int'(v.y[COORD_BITS-1:0]), int'(kept_y[s]));
      if (t > c) c = t;
      t = absd(int'(v.z[COORD_BITS-1:0]), int'(kept_z[s]));
      if (t > c) c = t;
      return c;
    endfunction

    function void store(int unsigned s, voxel_item_t v);
      kept_depth[s] = v.depth;
      kept_x[s]     = v.x[COORD_BITS-1:0];
      kept_y[s]     = v.y[COORD_BITS-1:0];
      kept_z[s]     = v.z[COORD_BITS-1:0];
    endfunction

    function void queue_report(peak_item_t item);
      report_q.insert(report_q.size(), item);
    endfunction

    // Merge with the first close peak, else append, else evict the shallowest.
    function void offer(voxel_item_t v);
      int unsigned lo;
      for (int unsigned i = 0; i < kept; i++) begin
        if (chebyshev(v, i) < separation) begin
          if (v.depth > kept_depth[i]) store(i, v);
          return;
        end
      end
      if (kept < slot_limit()) begin
        store(kept, v);
        kept++;
        return;
      end
      lo = 0;
      for (int unsigned i = 1; i < kept; i++)
        if (kept_depth[i] < kept_depth[lo]) lo = i;
      if (v.depth > kept_depth[lo]) store(lo, v);
    endfunction

    function void note_voxel(voxel_item_t v);
      peak_item_t  sorted [MAX_SLOTS];
      peak_item_t  empty_report;
      int unsigned rank;
      if (voxels < COUNT_SAT) voxels++;
      if (v.depth >= min_depth) offer(v);
      if (!v.last) return;
      if (kept == 0) begin
        empty_report = '{peak_valid: 1'b0, x: '0, y: '0, z: '0, depth: '0,
                         total: voxels, last: 1'b1};
        queue_report(empty_report);
      end else begin
        for (int unsigned i = 0; i < kept; i++) begin
          rank = 0;
          for (int unsigned j = 0; j < kept; j++)
            if (kept_depth[j] > kept_depth[i] || (kept_depth[j] == kept_depth[i] && j < i))
              rank++;
          sorted[rank] = '{peak_valid: 1'b1, x: kept_x[i], y: kept_y[i], z: kept_z[i],
                           depth: kept_depth[i], total: voxels, last: (rank == kept - 1)};
        end
        for (int unsigned r = 0; r < kept; r++) queue_report(sorted[r]);
      end
      kept   = 0;
      voxels = 0;
    endfunction

    function void check_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_peak(peak_item_t got);
      peak_item_t want;
      if (report_q.size() == 0) begin
        $error("peak result with no report pending");
        errors++;
        return;
      end
      want = report_q[0];
      report_q.delete(0);
      check_field("peak_valid", TOTAL_W'(want.peak_valid), TOTAL_W'(got.peak_valid));
      check_field("peak_x", TOTAL_W'(want.x), TOTAL_W'(got.x));
      check_field("peak_y", TOTAL_W'(want.y), TOTAL_W'(got.y));
      check_field("peak_z", TOTAL_W'(want.z), TOTAL_W'(got.z));
      check_field("peak_depth", TOTAL_W'(want.depth), TOTAL_W'(got.depth));
      check_field("voxel_total", want.total, got.total);
      check_field("last_result", TOTAL_W'(want.last), TOTAL_W'(got.last));
    endfunction

    function int unsigned pending();
      return report_q.size();
    endfunction
  endclass

endpackage

// ===== sim/tb.sv =====
// Top-level bench: drives voxels and register writes, checks peak reports.
`timescale 1ns / 1ps

module tb;
  import cpt_pkg::*;
  import peak_scoreboard_pkg::*;

  localparam int unsigned TOTAL_ITEMS   = 450;
  localparam int unsigned CALM_TAIL     = 60;   // items at the end with no idling
  localparam int unsigned LONG_HOLD     = 300;  // receiver back-pressure stretch
  // covers voxel update plus ranking and report drain of the largest table
  localparam int unsigned SETTLE_CYCLES = 4 * MAX_SLOTS + 8;
  localparam int unsigned QUIET_LIMIT   = 4000; // cycles without any handshake

  logic clk_i;
  logic rst_ni;

  cpt_voxel_if voxel_ch ();
  cpt_peak_if  peak_ch ();
  cpt_cfg_if   cfg_ch ();

  component_peak_tracker_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .voxel_i (voxel_ch),
    .peak_o  (peak_ch),
    .cfg_i   (cfg_ch)
  );

  peak_scoreboard sb = new();

  bit          no_idle;        // last part of the run: both sides stream
  bit          send_calm;      // sender stretch without gaps
  int unsigned items;          // voxels accepted so far
  int unsigned hold_requested; // bumped by stimulus to ask for a long stall
  int unsigned hold_served;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Offer one voxel, optionally after a random gap, and wait for its handshake.
  // valid stays high on return so back-to-back items need no extra edge.
  task automatic send_voxel(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                            input logic [FIELD_W-1:0] z, input logic [DEPTH_W-1:0] d,
                            input logic last);
    int unsigned gap;
    if (!no_idle && !send_calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      voxel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    voxel_ch.valid         <= 1'b1;
    voxel_ch.voxel_x       <= x;
    voxel_ch.voxel_y       <= y;
    voxel_ch.voxel_z       <= z;
    voxel_ch.depth         <= d;
    voxel_ch.component_end <= last;
    @(posedge clk_i);
    while (!voxel_ch.ready) @(posedge clk_i);
    sb.note_voxel('{x: x, y: y, z: z, depth: d, last: last});
    items++;
  endtask

  // Drop valid, wait for every pending report item, then let the core go idle.
  // Used before register writes and as the sender's full pause.
  task automatic settle();
    voxel_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_reg(idx, CFG_DATA_W'(value));
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register values weighted toward the edges: zero limits, saturating values.
  function automatic int unsigned random_value(cfg_reg_e sel);
    case (sel)
      CFG_MAX_PEAKS: begin
        case ($urandom_range(0, 5))
          0:       return 0;
          1:       return 15;
          2:       return MAX_SLOTS;
          3:       return 1;
          default: return $urandom_range(0, 15);
        endcase
      end
      CFG_SEPARATION: begin
        case ($urandom_range(0, 6))
          0:       return 0;
          1:       return 1024;
          2:       return 2047;
          3:       return $urandom_range(0, 2047);
          default: return $urandom_range(1, 40);
        endcase
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       return 0;
          1:       return 1023;
          2:       return $urandom_range(0, 1023);
          default: return $urandom_range(0, 300);
        endcase
      end
    endcase
  endfunction

  task automatic pick_config();
    settle();
    write_reg(CFG_MAX_PEAKS, random_value(CFG_MAX_PEAKS));
    write_reg(CFG_SEPARATION, random_value(CFG_SEPARATION));
    write_reg(CFG_MIN_DEPTH, random_value(CFG_MIN_DEPTH));
  endtask

  function automatic logic [FIELD_W-1:0] near(int c, int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return FIELD_W'(v);
  endfunction

  // Depth mostly around min_depth so candidates both pass and miss the cut.
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int d;
    case ($urandom_range(0, 3))
      0:       d = $urandom_range(0, 1023);
      1:       d = $urandom_range(0, sb.min_depth);
      default: d = int'(sb.min_depth) + int'($urandom_range(0, 43)) - 3;
    endcase
    if (d < 0) d = 0;
    if (d > 1023) d = 1023;
    return DEPTH_W'(d);
  endfunction

  // One component: voxels clustered around a center so merges happen, or
  // scattered over the whole volume so every coordinate bit toggles.
  task automatic gen_component(input int unsigned len);
    int       cx, cy, cz, spread;
    bit       wide;
    cfg_reg_e sel;
    logic [FIELD_W-1:0] x, y, z;
    wide   = ($urandom_range(0, 3) == 0);
    cx     = $urandom_range(0, 1023);
    cy     = $urandom_range(0, 1023);
    cz     = $urandom_range(0, 1023);
    spread = $urandom_range(1, 24);
    for (int unsigned k = 0; k < len; k++) begin
      if (wide) begin
        x = FIELD_W'($urandom_range(0, 1023));
        y = FIELD_W'($urandom_range(0, 1023));
        z = FIELD_W'($urandom_range(0, 1023));
      end else begin
        x = near(cx, spread);
        y = near(cy, spread);
        z = near(cz, spread);
      end
      send_voxel(x, y, z, pick_depth(), k == len - 1);
      // occasional register change in the middle of a component
      if (k != len - 1 && !no_idle && $urandom_range(0, 39) == 0) begin
        settle();
        sel = cfg_reg_e'($urandom_range(0, 2));
        write_reg(sel, random_value(sel));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left, gap_left, stretch_left;
    bit          stretch_calm;
    hold_left     = 0;
    gap_left      = 0;
    stretch_left  = 0;
    stretch_calm  = 1'b0;
    peak_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (peak_ch.valid && peak_ch.ready)
        sb.check_peak('{peak_valid: peak_ch.peak_valid, x: peak_ch.peak_x, y: peak_ch.peak_y,
                        z: peak_ch.peak_z, depth: peak_ch.peak_depth,
                        total: peak_ch.voxel_total, last: peak_ch.last_result});
      if (hold_served != hold_requested) begin
        hold_served = hold_requested;
        hold_left   = LONG_HOLD;
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 120);
        stretch_calm = ($urandom_range(0, 2) == 0);
      end
      stretch_left--;
      if (hold_left != 0) begin
        hold_left--;
        peak_ch.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        peak_ch.ready <= 1'b0;
      end else if (!no_idle && !stretch_calm && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        peak_ch.ready <= 1'b0;
      end else begin
        peak_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when no channel has moved an item for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((voxel_ch.valid && voxel_ch.ready) || (peak_ch.valid && peak_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no handshake for %0d cycles", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned comp, len;
    no_idle        = 1'b0;
    send_calm      = 1'b0;
    items          = 0;
    hold_requested = 0;
    hold_served    = 0;
    rst_ni                 <= 1'b0;
    voxel_ch.valid         <= 1'b0;
    voxel_ch.voxel_x       <= '0;
    voxel_ch.voxel_y       <= '0;
    voxel_ch.voxel_z       <= '0;
    voxel_ch.depth         <= '0;
    voxel_ch.component_end <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= CFG_MAX_PEAKS;
    cfg_ch.data            <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: 8 slots, separation 4, min_depth 1.
    // Lone voxel below min_depth: component without peaks.
    send_voxel(0, 0, 0, 0, 1'b1);
    // Merge chain: deeper close voxel replaces, shallower one is dropped,
    // far corner voxel is appended.
    send_voxel(10, 10, 10, 5, 1'b0);
    send_voxel(12, 13, 10, 7, 1'b0);
    send_voxel(11, 11, 11, 3, 1'b0);
    send_voxel(14, 10, 10, 9, 1'b0);
    send_voxel(1023, 1023, 1023, 1023, 1'b1);

    // Two slots, no suppression: identical voxels both kept, full table evicts
    // the shallowest (lowest slot on a tie), equal depths report slot order.
    settle();
    write_reg(CFG_MAX_PEAKS, 2);
    write_reg(CFG_SEPARATION, 0);
    send_voxel(5, 5, 5, 3, 1'b0);
    send_voxel(5, 5, 5, 3, 1'b0);
    send_voxel(700, 0, 1023, 2, 1'b0);
    send_voxel(0, 1023, 0, 8, 1'b1);
    send_voxel(1, 2, 3, 6, 1'b0);
    send_voxel(100, 200, 300, 6, 1'b1);

    // Zero slot limit acts as one; separation 1024 merges everything.
    settle();
    write_reg(CFG_MAX_PEAKS, 0);
    write_reg(CFG_SEPARATION, 1024);
    write_reg(CFG_MIN_DEPTH, 0);
    send_voxel(0, 0, 0, 0, 1'b0);
    send_voxel(1023, 1023, 1023, 0, 1'b0);
    send_voxel(512, 512, 512, 1023, 1'b1);

    // Slot limit above the table size clamps; top min_depth filters all but 1023.
    settle();
    write_reg(CFG_MAX_PEAKS, 15);
    write_reg(CFG_SEPARATION, 2047);
    write_reg(CFG_MIN_DEPTH, 1023);
    send_voxel(3, 3, 3, 1022, 1'b1);
    send_voxel(3, 4, 5, 1023, 1'b1);

    // Limit lowered mid-component: no more appends, eviction still scans all.
    settle();
    write_reg(CFG_MAX_PEAKS, 3);
    write_reg(CFG_SEPARATION, 2);
    write_reg(CFG_MIN_DEPTH, 1);
    send_voxel(0, 0, 0, 5, 1'b0);
    send_voxel(10, 0, 0, 6, 1'b0);
    send_voxel(20, 0, 0, 7, 1'b0);
    settle();
    write_reg(CFG_MAX_PEAKS, 1);
    send_voxel(30, 0, 0, 8, 1'b0);
    send_voxel(40, 0, 0, 4, 1'b1);

    // Random components under changing settings.
    comp = 0;
    while (items < TOTAL_ITEMS) begin
      no_idle = (items + CALM_TAIL >= TOTAL_ITEMS);
      if (comp % 8 == 0 && !no_idle) pick_config();
      // long receiver stall while voxels keep coming: report backs up, input stalls
      if (comp == 20) hold_requested++;
      // sender pause until the output side has drained completely
      if (comp == 36) settle();
      send_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(11, 24);
        default: len = $urandom_range(2, 10);
      endcase
      gen_component(len);
      comp++;
    end

    settle();
    if (sb.pending() != 0) begin
      $error("%0d report items never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
